// ===== sv/oriented_box_sdf_macros.svh =====
// Assertion macros for the oriented box distance block.
`ifndef ORIENTED_BOX_SDF_MACROS_SVH
`define ORIENTED_BOX_SDF_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define OBS_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define OBS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/obsdf_pkg.sv =====
// Shared constants for the oriented box distance block.
package obsdf_pkg;
    localparam int unsigned NUM_REGS = 8;
    localparam logic [2:0] REG_CENTRE_X = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y = 3'd1;
    localparam logic [2:0] REG_BASE_Z = 3'd2;
    localparam logic [2:0] REG_YAW_COS = 3'd3;
    localparam logic [2:0] REG_YAW_SIN = 3'd4;
    localparam logic [2:0] REG_HALF_W = 3'd5;
    localparam logic [2:0] REG_HALF_T = 3'd6;
    localparam logic [2:0] REG_HALF_H = 3'd7;
    localparam int unsigned MIN_HALF_W = 1638;
    localparam int unsigned MIN_HALF_T = 164;
    localparam int unsigned MIN_HALF_H = 1638;
    localparam int unsigned NORM_BITS = 30;
endpackage

// ===== sv/obsdf_sqrt_cell.sv =====
// One cell of the square root chain: settles one result bit per cycle while advance is high.
module obsdf_sqrt_cell #(
    parameter int SUM_W = 64,
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 32,
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic              advance,
    input  logic [SUM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [SUM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out,
    output logic [SIDE_W-1:0] side_out
);
    localparam int SH = 2 * (ROOT_W - 1 - STEP);
    logic              valid_reg;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;
    logic [SUM_W+1:0]  trial;

    // Try setting this bit: compare (2r+1) shifted against the remainder
    always_comb
    begin
        trial = ({{2{1'b0}}, {(SUM_W-ROOT_W){1'b0}}, root_in} << (ROOT_W - STEP))
              | ((SUM_W+2)'(1) << SH);
        if ({2'b00, rem_in} >= trial)
        begin
            rem_next = rem_in - trial[SUM_W-1:0];
            root_next = root_in | (ROOT_W'(1) << (ROOT_W - 1 - STEP));
        end
        else
        begin
            rem_next = rem_in;
            root_next = root_in;
        end
    end

    // Hold the beat while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

// ===== sv/obsdf_front.sv =====
// Front stages: offset, rotation, face excesses, scaling and sum of squares.
module obsdf_front #(
    parameter int CW = 24,
    parameter int FB = 16,
    parameter int SUM_W = 64,
    parameter int NB = 30
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    valid_in,
    input  logic signed [CW-1:0]    px_in,
    input  logic signed [CW-1:0]    py_in,
    input  logic signed [CW-1:0]    pz_in,
    input  logic signed [CW-1:0]    cx,
    input  logic signed [CW-1:0]    cy,
    input  logic signed [CW-1:0]    bz,
    input  logic signed [FB+1:0]    cosv,
    input  logic signed [FB+1:0]    sinv,
    input  logic [CW-2:0]           hw_in,
    input  logic [CW-2:0]           ht_in,
    input  logic [CW-2:0]           hh_in,
    output logic                    valid_out,
    output logic [SUM_W-1:0]        sum_out,
    output logic [5:0]              shift_out,
    output logic signed [CW+3:0]    inside_out
);
    import obsdf_pkg::*;
    localparam int DW = CW + 1;
    localparam int PW = DW + FB + 2;
    localparam int LW = PW + 1;
    localparam int EW = LW + 2;
    localparam int CLW = CW;

    logic [3:0] v_reg;

    // Stage 1: offsets and clamped sizes
    logic signed [DW-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic [CW-2:0] hw1_reg, ht1_reg, hh1_reg;
    logic [CW-2:0] hw_c, ht_c, hh_c;
    always_comb
    begin
        hw_c = (hw_in < (CW-1)'(MIN_HALF_W)) ? (CW-1)'(MIN_HALF_W) : hw_in;
        ht_c = (ht_in < (CW-1)'(MIN_HALF_T)) ? (CW-1)'(MIN_HALF_T) : ht_in;
        hh_c = (hh_in < (CW-1)'(MIN_HALF_H)) ? (CW-1)'(MIN_HALF_H) : hh_in;
    end

    // Stage 2: four products
    logic signed [PW-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [DW+1:0] lz2_reg;
    logic [CW-2:0] hw2_reg, ht2_reg, hh2_reg;

    // Stage 3: rotation rounding and excesses
    logic signed [EW-1:0] ex3_reg, ey3_reg, ez3_reg;
    logic signed [LW-1:0] sx, sy, lx, ly;
    logic signed [LW-1:0] ax, ay;
    logic signed [DW+1:0] az0;
    always_comb
    begin
        sx = LW'(pxc_reg) - LW'(pys_reg) + LW'(1 <<< (FB-1));
        sy = LW'(pxs_reg) + LW'(pyc_reg) + LW'(1 <<< (FB-1));
        lx = sx >>> FB;
        ly = sy >>> FB;
        ax = (lx < 0) ? -lx : lx;
        ay = (ly < 0) ? -ly : ly;
        az0 = lz2_reg - $signed({3'b000, hh2_reg});
        if (az0 < 0)
            az0 = -az0;
    end

    // Stage 4: clip, scale and square
    logic signed [EW-1:0] inside_c;
    logic [CLW-1:0] qa, qb, qc, qm;
    logic [5:0] sh_c;
    logic [CLW-1:0] qa_s, qb_s, qc_s;
    logic [SUM_W-1:0] sq_reg;
    logic [5:0] sh4_reg;
    logic signed [CW+3:0] in4_reg;
    localparam logic [CLW-1:0] LIM = CLW'(1) << (CW-1);

    function automatic logic [CLW-1:0] clip_pos(input logic signed [EW-1:0] e);
        if (e <= 0)
            return '0;
        else if (e >= $signed({{(EW-CLW){1'b0}}, LIM}))
            return LIM;
        else
            return CLW'(e);
    endfunction

    always_comb
    begin
        qa = clip_pos(ex3_reg);
        qb = clip_pos(ey3_reg);
        qc = clip_pos(ez3_reg);
        qm = (qa > qb) ? qa : qb;
        if (qc > qm)
            qm = qc;
        sh_c = '0;
        for (int i = 0; i < CLW; i++)
        begin
            if (i >= NB && qm[i])
                sh_c = 6'(i - NB + 1);
        end
        qa_s = qa >> sh_c;
        qb_s = qb >> sh_c;
        qc_s = qc >> sh_c;
        inside_c = (ex3_reg > ey3_reg) ? ex3_reg : ey3_reg;
        if (ez3_reg > inside_c)
            inside_c = ez3_reg;
        if (inside_c > 0)
            inside_c = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[2:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx1_reg <= DW'(px_in) - DW'(cx);
            dy1_reg <= DW'(py_in) - DW'(cy);
            dz1_reg <= DW'(pz_in) - DW'(bz);
            hw1_reg <= hw_c;
            ht1_reg <= ht_c;
            hh1_reg <= hh_c;
            pxc_reg <= PW'(dx1_reg) * PW'(cosv);
            pys_reg <= PW'(dy1_reg) * PW'(sinv);
            pxs_reg <= PW'(dx1_reg) * PW'(sinv);
            pyc_reg <= PW'(dy1_reg) * PW'(cosv);
            lz2_reg <= (DW+2)'(dz1_reg);
            hw2_reg <= hw1_reg;
            ht2_reg <= ht1_reg;
            hh2_reg <= hh1_reg;
            ex3_reg <= EW'(ax) - $signed({{(EW-CW+1){1'b0}}, hw2_reg});
            ey3_reg <= EW'(ay) - $signed({{(EW-CW+1){1'b0}}, ht2_reg});
            ez3_reg <= EW'(az0) - $signed({{(EW-CW+1){1'b0}}, hh2_reg});
            sq_reg <= SUM_W'(qa_s) * SUM_W'(qa_s) + SUM_W'(qb_s) * SUM_W'(qb_s)
                    + SUM_W'(qc_s) * SUM_W'(qc_s);
            sh4_reg <= sh_c;
            in4_reg <= (CW+4)'(inside_c);
        end
    end

    assign valid_out = v_reg[3];
    assign sum_out = sq_reg;
    assign shift_out = sh4_reg;
    assign inside_out = in4_reg;
endmodule

// ===== sv/oriented_box_sdf.sv =====
// Pipeline: 4 front stages, one chain cell per root bit
// (25 cells at COORD_WIDTH 24, at most 31), one output stage.
// Throughput: one point per cycle while the output is not stalled; the chain of square root cells sets the depth.
// The squaring stage holds three multipliers of at most 30 bits each.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// The output stall reaches in_stall combinationally; a stall freezes the whole chain.
module oriented_box_sdf #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] distance,
    output logic                          saturated,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data
);
    import obsdf_pkg::*;
    `include "oriented_box_sdf_macros.svh"
    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int QW = (CW - 1 < NORM_BITS) ? CW : NORM_BITS;
    localparam int ROOT_W = QW + 1;
    localparam int SUM_W = 2 * ROOT_W;
    localparam int SIDE_W = CW + 4 + 6;

    // Configuration registers
    logic signed [CW-1:0] cx_reg, cy_reg, bz_reg;
    logic signed [FB+1:0] cos_reg, sin_reg;
    logic [CW-2:0] hw_reg, ht_reg, hh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            bz_reg <= '0;
            cos_reg <= (FB+2)'(1) << FB;
            sin_reg <= '0;
            hw_reg <= (CW-1)'(1) << (FB-1);
            ht_reg <= (CW-1)'(((64'd3277) << FB) >> 16);
            hh_reg <= (CW-1)'(1) << FB;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTRE_X: cx_reg <= cfg_data;
                REG_CENTRE_Y: cy_reg <= cfg_data;
                REG_BASE_Z:   bz_reg <= cfg_data;
                REG_YAW_COS:  cos_reg <= cfg_data[FB+1:0];
                REG_YAW_SIN:  sin_reg <= cfg_data[FB+1:0];
                REG_HALF_W:   hw_reg <= cfg_data[CW-2:0];
                REG_HALF_T:   ht_reg <= cfg_data[CW-2:0];
                REG_HALF_H:   hh_reg <= cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // Whole pipe advances unless the output holds a beat that is stalled
    logic advance;
    logic out_valid_reg;
    assign advance = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    logic f_valid;
    logic [SUM_W-1:0] f_sum;
    logic [5:0] f_sh;
    logic signed [CW+3:0] f_in;
    obsdf_front #(.CW(CW), .FB(FB), .SUM_W(SUM_W), .NB(NORM_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .advance(advance), .valid_in(in_valid),
        .px_in(point_x), .py_in(point_y), .pz_in(point_z),
        .cx(cx_reg), .cy(cy_reg), .bz(bz_reg), .cosv(cos_reg), .sinv(sin_reg),
        .hw_in(hw_reg), .ht_in(ht_reg), .hh_in(hh_reg),
        .valid_out(f_valid), .sum_out(f_sum), .shift_out(f_sh), .inside_out(f_in)
    );

    // Chain of root cells, one bit each
    logic [ROOT_W:0] cv;
    logic [SUM_W-1:0] crem [ROOT_W+1];
    logic [ROOT_W-1:0] croot [ROOT_W+1];
    logic [SIDE_W-1:0] cside [ROOT_W+1];
    assign cv[0] = f_valid;
    assign crem[0] = f_sum;
    assign croot[0] = '0;
    assign cside[0] = {f_sh, f_in};
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_cell
        obsdf_sqrt_cell #(.SUM_W(SUM_W), .ROOT_W(ROOT_W), .SIDE_W(SIDE_W), .STEP(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .valid_in(cv[g]), .advance(advance),
            .rem_in(crem[g]), .root_in(croot[g]), .side_in(cside[g]),
            .valid_out(cv[g+1]), .rem_out(crem[g+1]), .root_out(croot[g+1]),
            .side_out(cside[g+1])
        );
    end

    // Round, rescale, add inside term and saturate
    logic [ROOT_W-1:0] r_end;
    logic [SUM_W-1:0] rem_end;
    logic [5:0] sh_end;
    logic signed [CW+3:0] in_end;
    logic signed [CW+12:0] dsum;
    logic [CW+9:0] norm;
    logic signed [CW-1:0] dist_next;
    logic sat_next;
    localparam logic signed [CW+12:0] HI = (CW+13)'((64'd1 << (CW-1)) - 1);
    localparam logic signed [CW+12:0] LO = -HI - 1;
    always_comb
    begin
        r_end = croot[ROOT_W];
        rem_end = crem[ROOT_W];
        {sh_end, in_end} = cside[ROOT_W];
        norm = (CW+10)'(r_end) + (CW+10)'(rem_end > SUM_W'(r_end));
        norm = norm << sh_end;
        dsum = $signed({3'b000, norm}) + (CW+13)'(in_end);
        sat_next = 1'b0;
        dist_next = CW'(dsum);
        if (dsum > HI)
        begin
            dist_next = CW'(HI);
            sat_next = 1'b1;
        end
        else if (dsum < LO)
        begin
            dist_next = CW'(LO);
            sat_next = 1'b1;
        end
    end

    logic signed [CW-1:0] dist_reg;
    logic sat_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= cv[ROOT_W];
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dist_reg <= dist_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance = dist_reg;
    assign saturated = sat_reg;

    `OBS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(distance))
    `OBS_ASSERT_IMPL(a_stall, clk, rst_n, in_stall, out_valid && out_stall)
    `OBS_ASSERT_IMPL(a_satval, clk, rst_n, out_valid && saturated, distance[CW-1] != distance[0] || distance[CW-1] == distance[1])
endmodule
